// ----- sv/sskt_pkg.sv -----
`default_nettype none
package sskt_pkg;

   localparam int SLOTS      = 4;
   localparam int CHILD_BITS = 32;
   localparam int IDX_BITS   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int COUNT_BITS = $clog2(SLOTS + 1);

   localparam logic [2:0] CMD_FIND   = 3'd0;
   localparam logic [2:0] CMD_INSERT = 3'd1;
   localparam logic [2:0] CMD_DELETE = 3'd2;
   localparam logic [2:0] CMD_NEXT   = 3'd3;
   localparam logic [2:0] CMD_PREV   = 3'd4;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   typedef logic [7:0]            key_type;
   typedef logic [CHILD_BITS-1:0] child_type;
   typedef logic [COUNT_BITS-1:0] count_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic execute;
   } ctrl_type;

endpackage
`default_nettype wire

// ----- sv/sskt_ctrl.sv -----
`default_nettype none
module sskt_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output sskt_pkg::ctrl_type     ctrl
);
   import sskt_pkg::*;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_comb begin
      ctrl.capture = (state_ff == S_IDLE) && req_valid;
      // The result register must be free, or be emptied this cycle, before a
      // command may overwrite it.
      ctrl.execute = (state_ff == S_EXEC) && (!rsp_valid_ff || !rsp_stall);
      rsp_valid_in = ctrl.execute || (rsp_valid_ff && rsp_stall);
      state_in     = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (ctrl.capture) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (ctrl.execute) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff == S_EXEC);
   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// ----- sv/sskt_datapath.sv -----
`default_nettype none
module sskt_datapath (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire sskt_pkg::ctrl_type    ctrl,
   input  wire logic [2:0]            req_command,
   input  wire logic [7:0]            req_key,
   input  wire logic [31:0]           req_child_value,
   output logic [1:0]                 rsp_status,
   output logic [31:0]                rsp_child_out,
   output logic [7:0]                 rsp_key_out,
   output sskt_pkg::count_type        rsp_entry_count,
   output logic                       rsp_is_full
);
   import sskt_pkg::*;

   logic [2:0] cmd_ff;
   key_type    key_ff;
   child_type  val_ff;

   key_type   keys_ff [SLOTS];
   key_type   keys_in [SLOTS];
   child_type kids_ff [SLOTS];
   child_type kids_in [SLOTS];
   count_type count_ff, count_in;

   logic [1:0] status_ff, status_in;
   logic [31:0] child_out_ff, child_out_in;
   key_type    key_out_ff, key_out_in;
   count_type  entry_ff;
   logic       full_ff;

   logic [63:0] wide_val;
   key_type     up_keys [SLOTS];
   child_type   up_kids [SLOTS];
   key_type     dn_keys [SLOTS];
   child_type   dn_kids [SLOTS];
   logic [SLOTS-1:0] live, eq, le, ge;

   always_comb begin
      logic [IDX_BITS-1:0] first_eq, first_ge, last_le;
      logic       any_eq, any_ge, any_le, table_full;
      count_type  pos;
      first_eq = '0;
      first_ge = '0;
      last_le  = '0;
      pos      = '0;
      for (int i = 0; i < SLOTS; i++) begin
         live[i] = (COUNT_BITS'(i) < count_ff);
         eq[i]   = live[i] && (keys_ff[i] == key_ff);
         le[i]   = live[i] && (keys_ff[i] <= key_ff);
         ge[i]   = live[i] && (keys_ff[i] >= key_ff);
         pos     = pos + COUNT_BITS'(le[i]);
         if (le[i]) last_le = IDX_BITS'(i);
      end
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (eq[i]) first_eq = IDX_BITS'(i);
         if (ge[i]) first_ge = IDX_BITS'(i);
      end
      any_eq     = |eq;
      any_ge     = |ge;
      any_le     = |le;
      table_full = (count_ff >= COUNT_BITS'(SLOTS));

      // Neighbor views of the slots: one slot up for insert, one down for delete.
      up_keys[0] = '0;
      up_kids[0] = '0;
      for (int i = 1; i < SLOTS; i++) begin
         up_keys[i] = keys_ff[i-1];
         up_kids[i] = kids_ff[i-1];
      end
      for (int i = 0; i < SLOTS - 1; i++) begin
         dn_keys[i] = keys_ff[i+1];
         dn_kids[i] = kids_ff[i+1];
      end
      dn_keys[SLOTS-1] = '0;
      dn_kids[SLOTS-1] = '0;

      wide_val     = 64'(val_ff);
      keys_in      = keys_ff;
      kids_in      = kids_ff;
      count_in     = count_ff;
      status_in    = ST_MISS;
      child_out_in = '0;
      key_out_in   = '0;

      unique case (cmd_ff)
         CMD_FIND: begin
            if (any_eq) begin
               status_in    = ST_OK;
               wide_val     = 64'(kids_ff[first_eq]);
               child_out_in = wide_val[31:0];
            end
         end
         CMD_INSERT: begin
            if (table_full) begin
               status_in = ST_FULL;
            end else begin
               status_in = ST_OK;
               count_in  = count_ff + COUNT_BITS'(1);
               for (int i = 0; i < SLOTS; i++) begin
                  if (COUNT_BITS'(i) == pos) begin
                     keys_in[i] = key_ff;
                     kids_in[i] = val_ff;
                  end else if (COUNT_BITS'(i) > pos && COUNT_BITS'(i) <= count_ff) begin
                     keys_in[i] = up_keys[i];
                     kids_in[i] = up_kids[i];
                  end
               end
            end
         end
         CMD_DELETE: begin
            if (any_eq) begin
               status_in = ST_OK;
               count_in  = count_ff - COUNT_BITS'(1);
               // Slots above the live range hold zero, so pulling down also
               // clears the vacated top slot.
               for (int i = 0; i < SLOTS; i++) begin
                  if (IDX_BITS'(i) >= first_eq && live[i]) begin
                     keys_in[i] = dn_keys[i];
                     kids_in[i] = dn_kids[i];
                  end
               end
            end
         end
         CMD_NEXT: begin
            if (any_ge) begin
               status_in  = ST_OK;
               key_out_in = keys_ff[first_ge];
            end
         end
         CMD_PREV: begin
            if (any_le) begin
               status_in  = ST_OK;
               key_out_in = keys_ff[last_le];
            end
         end
         default: status_in = ST_MISS;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         cmd_ff <= req_command;
         key_ff <= req_key;
         val_ff <= CHILD_BITS'(64'(req_child_value));
      end
      if (ctrl.execute) begin
         status_ff    <= status_in;
         child_out_ff <= child_out_in;
         key_out_ff   <= key_out_in;
         entry_ff     <= count_in;
         full_ff      <= (count_in >= COUNT_BITS'(SLOTS));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         for (int i = 0; i < SLOTS; i++) begin
            keys_ff[i] <= '0;
            kids_ff[i] <= '0;
         end
      end else if (ctrl.execute) begin
         count_ff <= count_in;
         keys_ff  <= keys_in;
         kids_ff  <= kids_in;
      end
   end

   assign rsp_status      = status_ff;
   assign rsp_child_out   = child_out_ff;
   assign rsp_key_out     = key_out_ff;
   assign rsp_entry_count = entry_ff;
   assign rsp_is_full     = full_ff;

endmodule
`default_nettype wire

// ----- sv/sorted_small_key_table.sv -----
// Sorted table of up to four byte keys, each with a child handle, kept in
// ascending unsigned order. Commands are find, insert (after equal keys),
// delete (first equal key), next key at or above and previous key at or
// below; every command yields exactly one result transaction carrying the
// status, the found handle or neighbor key, and the entry count afterwards.
// A command is captured first; then the compare and shift logic over the slot
// registers runs and loads the result register.
// The result register lets the next command be captured while a result still
// waits; a command then holds in execution until that result is taken.
`default_nettype none
module sorted_small_key_table (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [2:0]            req_command,
   input  wire logic [7:0]            req_key,
   input  wire logic [31:0]           req_child_value,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [1:0]                 rsp_status,
   output logic [31:0]                rsp_child_out,
   output logic [7:0]                 rsp_key_out,
   output sskt_pkg::count_type        rsp_entry_count,
   output logic                       rsp_is_full
);
   import sskt_pkg::*;

   ctrl_type ctrl;

   sskt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctrl      (ctrl)
   );

   sskt_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .req_command     (req_command),
      .req_key         (req_key),
      .req_child_value (req_child_value),
      .rsp_status      (rsp_status),
      .rsp_child_out   (rsp_child_out),
      .rsp_key_out     (rsp_key_out),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_full     (rsp_is_full)
   );

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("command accepted while another was in flight");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_entry_count <= COUNT_BITS'(SLOTS)))
      else $error("entry count above slot count");

   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_full == (rsp_entry_count == COUNT_BITS'(SLOTS))))
      else $error("full flag disagrees with entry count");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_FULL)) |-> rsp_is_full)
      else $error("full status reported on a table with free slots");

endmodule
`default_nettype wire

// ----- tb/tb_sorted_small_key_table.sv -----
`default_nettype none
module tb_sorted_small_key_table;
   timeunit 1ns;
   timeprecision 1ps;

   import sskt_pkg::*;

   // Command codes that the block leaves unused.
   localparam logic [2:0] CMD_SPARE_LO = 3'd5;
   localparam logic [2:0] CMD_SPARE_HI = 3'd7;

   localparam int RANDOM_PER_PHASE = 345;
   localparam int POOL_SIZE        = 6;
   localparam int HOLD_CYCLES      = 80;
   localparam int DRAIN_LIMIT      = 10000;
   localparam int TAIL_CYCLES      = 10;

   typedef struct packed {
      logic [1:0] status;
      child_type  child;
      key_type    key;
      count_type  count;
      logic       full;
   } table_result_type;

   class key_table_tracker;
      key_type          keys [SLOTS];
      child_type        children [SLOTS];
      int               used;
      table_result_type awaited_results [$];
      int               errors;

      function new();
         for (int i = 0; i < SLOTS; i++) begin
            keys[i]     = '0;
            children[i] = '0;
         end
         used   = 0;
         errors = 0;
      endfunction

      function int pending();
         return awaited_results.size();
      endfunction

      // Advances the table copy by one accepted command and queues its result.
      function void note_command(logic [2:0] cmd, key_type key, child_type child);
         table_result_type r;
         int               pos;
         r        = '0;
         r.status = ST_MISS;
         case (cmd)
            CMD_FIND: begin
               for (int i = 0; i < used; i++) begin
                  if (keys[i] == key) begin
                     r.child  = children[i];
                     r.status = ST_OK;
                     break;
                  end
               end
            end
            CMD_INSERT: begin
               if (used >= SLOTS) begin
                  r.status = ST_FULL;
               end else begin
                  pos = 0;
                  while (pos < used && keys[pos] <= key) pos++;
                  for (int i = used; i > pos; i--) begin
                     keys[i]     = keys[i-1];
                     children[i] = children[i-1];
                  end
                  keys[pos]     = key;
                  children[pos] = child;
                  used++;
                  r.status = ST_OK;
               end
            end
            CMD_DELETE: begin
               for (int i = 0; i < used; i++) begin
                  if (keys[i] == key) begin
                     for (int j = i; j + 1 < used; j++) begin
                        keys[j]     = keys[j+1];
                        children[j] = children[j+1];
                     end
                     keys[used-1]     = '0;
                     children[used-1] = '0;
                     used--;
                     r.status = ST_OK;
                     break;
                  end
               end
            end
            CMD_NEXT: begin
               for (int i = 0; i < used; i++) begin
                  if (keys[i] >= key) begin
                     r.key    = keys[i];
                     r.status = ST_OK;
                     break;
                  end
               end
            end
            CMD_PREV: begin
               for (int i = used - 1; i >= 0; i--) begin
                  if (keys[i] <= key) begin
                     r.key    = keys[i];
                     r.status = ST_OK;
                     break;
                  end
               end
            end
            default: begin
            end
         endcase
         r.count = count_type'(used);
         r.full  = (used >= SLOTS);
         awaited_results.push_back(r);
      endfunction

      function void check_result(table_result_type got);
         table_result_type exp;
         if (awaited_results.size() == 0) begin
            $error("result transaction arrived with nothing expected");
            errors++;
            return;
         end
         exp = awaited_results.pop_front();
         if (got.status !== exp.status) begin
            $error("status: expected %0d, actual %0d", exp.status, got.status);
            errors++;
         end
         if (got.child !== exp.child) begin
            $error("child_out: expected %0h, actual %0h", exp.child, got.child);
            errors++;
         end
         if (got.key !== exp.key) begin
            $error("key_out: expected %0d, actual %0d", exp.key, got.key);
            errors++;
         end
         if (got.count !== exp.count) begin
            $error("entry_count: expected %0d, actual %0d", exp.count, got.count);
            errors++;
         end
         if (got.full !== exp.full) begin
            $error("is_full: expected %0d, actual %0d", exp.full, got.full);
            errors++;
         end
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [2:0] req_command;
   key_type    req_key;
   child_type  req_child_value;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [1:0] rsp_status;
   child_type  rsp_child_out;
   key_type    rsp_key_out;
   count_type  rsp_entry_count;
   logic       rsp_is_full;

   key_table_tracker tracker = new();

   int      sender_idle_pct;
   int      receiver_stall_pct;
   key_type key_pool [POOL_SIZE];

   sorted_small_key_table uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_key         (req_key),
      .req_child_value (req_child_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_child_out   (rsp_child_out),
      .rsp_key_out     (rsp_key_out),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_full     (rsp_is_full)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("tb_sorted_small_key_table NOT OK");
      $finish;
   end

   // Offers one command and returns once the block has taken the transaction.
   task automatic send_command(input logic [2:0] cmd, input key_type key,
                               input child_type child);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_key         <= key;
      req_child_value <= child;
      do @(posedge clock); while (req_stall);
      tracker.note_command(cmd, key, child);
   endtask

   task automatic wait_for_drain();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (tracker.pending() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (tracker.pending() != 0) begin
         $display("tb_sorted_small_key_table NOT OK");
         $finish;
      end
   endtask

   task automatic refresh_pool();
      for (int i = 0; i < POOL_SIZE; i++) begin
         case ($urandom_range(9))
            0:       key_pool[i] = '0;
            1:       key_pool[i] = '1;
            default: key_pool[i] = key_type'($urandom_range(255));
         endcase
      end
   endtask

   function automatic key_type pick_key();
      // Most keys come from a small pool so that finds and deletes hit.
      if ($urandom_range(99) < 75) return key_pool[$urandom_range(POOL_SIZE - 1)];
      return key_type'($urandom_range(255));
   endfunction

   function automatic logic [2:0] pick_command();
      int r;
      r = $urandom_range(99);
      if (r < 30) return CMD_INSERT;
      if (r < 55) return CMD_DELETE;
      if (r < 70) return CMD_FIND;
      if (r < 82) return CMD_NEXT;
      if (r < 94) return CMD_PREV;
      return 3'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
   endfunction

   task automatic run_random(input int count);
      for (int n = 0; n < count; n++) begin
         if (n % 40 == 0) refresh_pool();
         send_command(pick_command(), pick_key(), child_type'($urandom()));
      end
   endtask

   initial begin : receiver
      int               checked;
      int               hold_left;
      table_result_type got;
      checked   = 0;
      hold_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got.status = rsp_status;
            got.child  = rsp_child_out;
            got.key    = rsp_key_out;
            got.count  = rsp_entry_count;
            got.full   = rsp_is_full;
            tracker.check_result(got);
            checked++;
            // Long back-pressure so that the block fills and stalls its input.
            if (checked == 200 || checked == 650) hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
         end
      end
   end

   initial begin : stimulus
      int waited;
      sender_idle_pct    = 21;
      receiver_stall_pct = 52;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_command     <= CMD_FIND;
      req_key         <= '0;
      req_child_value <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Every query on an empty table misses.
      send_command(CMD_FIND, 8'd0, '1);
      send_command(CMD_DELETE, 8'd0, '0);
      send_command(CMD_NEXT, 8'd0, '0);
      send_command(CMD_PREV, 8'd255, '0);
      // Fill to capacity, with a duplicate key, then try one more insert.
      send_command(CMD_INSERT, 8'd255, '1);
      send_command(CMD_INSERT, 8'd0, 32'h0000_0001);
      send_command(CMD_INSERT, 8'd0, 32'h8000_0000);
      send_command(CMD_INSERT, 8'd128, 32'h5555_aaaa);
      send_command(CMD_INSERT, 8'd7, 32'h1234_5678);
      send_command(CMD_FIND, 8'd0, '0);
      send_command(CMD_FIND, 8'd255, '0);
      send_command(CMD_FIND, 8'd1, '0);
      send_command(CMD_NEXT, 8'd1, '0);
      send_command(CMD_NEXT, 8'd255, '0);
      send_command(CMD_PREV, 8'd254, '0);
      send_command(CMD_PREV, 8'd0, '0);
      for (int c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++) begin
         send_command(3'(c), 8'd0, '1);
      end
      // Deleting the first of two equal keys leaves the second one's handle.
      send_command(CMD_DELETE, 8'd0, '0);
      send_command(CMD_FIND, 8'd0, '0);
      send_command(CMD_DELETE, 8'd255, '0);
      send_command(CMD_NEXT, 8'd129, '0);
      send_command(CMD_DELETE, 8'd0, '0);
      send_command(CMD_DELETE, 8'd128, '0);
      send_command(CMD_PREV, 8'd255, '0);

      run_random(RANDOM_PER_PHASE);

      // The sender stops here until every result has been taken.
      wait_for_drain();
      sender_idle_pct    = 52;
      receiver_stall_pct = 21;
      run_random(RANDOM_PER_PHASE);

      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      run_random(RANDOM_PER_PHASE);

      req_valid <= 1'b0;
      waited = 0;
      while (tracker.pending() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (tracker.pending() != 0) begin
         $display("tb_sorted_small_key_table NOT OK");
         $finish;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (tracker.pending() != 0) begin
         $error("%0d expected results never arrived", tracker.pending());
         tracker.errors++;
      end
      if (tracker.errors == 0) begin
         $display("tb_sorted_small_key_table OK");
      end else begin
         $display("tb_sorted_small_key_table NOT OK");
      end
      $finish;
   end

endmodule
`default_nettype wire
